FILE: rtl/bqd_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Biquad low-pass package
// Shared constants and types for the fixed-point low-pass biquad core.
// -----------------------------------------------------------------------------
package bqd_pkg;

    // Accumulator and internal output width
    localparam int ACC_BITS      = 32;
    // Extra shift between the internal output and the result sample
    localparam int RADIX_SHIFT   = 3;

    // Register widths
    localparam int GAIN_BITS     = 25;
    localparam int FB_BITS       = 26;
    localparam int SHIFT_BITS    = 5;
    localparam int CFG_DATA_BITS = 26;
    localparam int CFG_IDX_BITS  = 2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_ONE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_TWO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_SHIFT  = 2'd3;

    // Filter settings as seen by the datapath
    typedef struct packed {
        logic        [GAIN_BITS-1:0]  tap_gain;
        logic        [FB_BITS-1:0]    feedback_one;
        logic signed [FB_BITS-1:0]    feedback_two;
        logic        [SHIFT_BITS-1:0] scale_shift;
    } bqd_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/bqd_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Biquad sample channels
// Valid/ready channels carrying raw samples in and filtered samples out.
// -----------------------------------------------------------------------------
interface bqd_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqd_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/bqd_cfg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Biquad configuration registers
// Write-only register file holding gain, feedback coefficients and shift.
// -----------------------------------------------------------------------------
module bqd_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bqd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [bqd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output bqd_pkg::bqd_cfg_t                      cfg
);

    bqd_pkg::bqd_cfg_t cfg_reg;
    bqd_pkg::bqd_cfg_t cfg_next;

    // Decode the write into the addressed register, dropping unused high bits
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bqd_pkg::CFG_TAP_GAIN:
                    cfg_next.tap_gain = cfg_data[bqd_pkg::GAIN_BITS-1:0];
                bqd_pkg::CFG_FEEDBACK_ONE:
                    cfg_next.feedback_one = cfg_data[bqd_pkg::FB_BITS-1:0];
                bqd_pkg::CFG_FEEDBACK_TWO:
                    cfg_next.feedback_two = $signed(cfg_data[bqd_pkg::FB_BITS-1:0]);
                bqd_pkg::CFG_SCALE_SHIFT:
                    cfg_next.scale_shift = cfg_data[bqd_pkg::SHIFT_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: rtl/bqd_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Biquad datapath
// Sample history, feed-forward and feedback products, shift and saturation.
// -----------------------------------------------------------------------------
module bqd_dp #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic signed [SAMPLE_BITS-1:0] x_cur,
    input  wire bqd_pkg::bqd_cfg_t             cfg,
    output logic signed [SAMPLE_BITS-1:0]      result
);

    localparam int ACC = bqd_pkg::ACC_BITS;
    localparam int FFW = SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] x_m1_reg;
    logic signed [SAMPLE_BITS-1:0] x_m2_reg;
    logic        [ACC-1:0]         y_m1_reg;
    logic        [ACC-1:0]         y_m2_reg;

    logic signed [FFW-1:0]         ff_sum;
    logic        [ACC-1:0]         ff_ext;
    logic        [ACC-1:0]         gain_ext;
    logic        [ACC-1:0]         fb1_ext;
    logic        [ACC-1:0]         fb2_ext;
    logic        [ACC-1:0]         prod_ff;
    logic        [ACC-1:0]         prod_fb1;
    logic        [ACC-1:0]         prod_fb2;
    logic        [ACC-1:0]         acc;
    logic        [ACC-1:0]         y_new;
    logic        [ACC-1:0]         r_shift;
    logic                          fits;

    // Binomial feed-forward sum x[n] + 2*x[n-1] + x[n-2]
    assign ff_sum = FFW'(x_cur) + (FFW'(x_m1_reg) <<< 1) + FFW'(x_m2_reg);

    // Extend operands to the accumulator width; products keep the low word
    assign ff_ext   = ACC'(ff_sum);
    assign gain_ext = ACC'(cfg.tap_gain);
    assign fb1_ext  = ACC'(cfg.feedback_one);
    assign fb2_ext  = ACC'(cfg.feedback_two);

    assign prod_ff  = ff_ext * gain_ext;
    assign prod_fb1 = fb1_ext * y_m1_reg;
    assign prod_fb2 = fb2_ext * y_m2_reg;

    // Wrapped total, then the configured arithmetic shift
    assign acc   = prod_ff + prod_fb2 + prod_fb1;
    assign y_new = ACC'($signed(acc) >>> cfg.scale_shift);

    // Drop the radix bits and clamp to the sample range
    assign r_shift = ACC'($signed(y_new) >>> bqd_pkg::RADIX_SHIFT);
    assign fits    = (&r_shift[ACC-1:SAMPLE_BITS-1]) || !(|r_shift[ACC-1:SAMPLE_BITS-1]);

    always_comb
    begin
        if (fits)
        begin
            result = $signed(r_shift[SAMPLE_BITS-1:0]);
        end
        else if (r_shift[ACC-1])
        begin
            result = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        end
        else
        begin
            result = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        end
    end

    // Advance the sample and output history once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_m1_reg <= '0;
            x_m2_reg <= '0;
            y_m1_reg <= '0;
            y_m2_reg <= '0;
        end
        else if (step)
        begin
            x_m2_reg <= x_m1_reg;
            x_m1_reg <= x_cur;
            y_m2_reg <= y_m1_reg;
            y_m1_reg <= y_new;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fixed_point_lowpass_biquad_core.sv
// An accepted request waits in the input register, its result in the result
// register. One sample per cycle unless the result stalls; the y[n-1] feedback
// loop through the three products, the sum and the shift closes in the single
// compute stage. A stalled result holds the compute stage; one more request is
// still taken. Reset (rst_n, asynchronous, active low) clears the settings, the
// sample and output history and all valid flags.
`default_nettype none
// -----------------------------------------------------------------------------
// Fixed-point low-pass biquad core
// Input register, single-pass filter stage and result register.
// -----------------------------------------------------------------------------
module fixed_point_lowpass_biquad_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bqd_in_if.sink                                 upstream,
    bqd_out_if.source                              downstream,
    input  wire logic                              cfg_we,
    input  wire logic [bqd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [bqd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    bqd_pkg::bqd_cfg_t             cfg;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic signed [SAMPLE_BITS-1:0] result;
    logic                          advance;
    logic                          take;
    logic                          step;

    bqd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bqd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .x_cur  (x_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Handshake: the compute stage moves when the result register is free
    assign advance         = !out_valid_reg || downstream.ready;
    assign upstream.ready  = !in_valid_reg || advance;
    assign take            = upstream.valid && upstream.ready;
    assign step            = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= upstream.sample_in;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign downstream.valid      = out_valid_reg;
    assign downstream.sample_out = out_data_reg;

endmodule
`default_nettype wire

FILE: rtl/bqd_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Biquad port checker
// Concurrent checks on the sample channels of the biquad core.
// -----------------------------------------------------------------------------
module bqd_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] out_data
);

    // Hold a result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

    // Hold the result value while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

    // No result right after reset release
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

    // An empty result side never blocks a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("request blocked with no pending result");

    // Every accepted request is followed by a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted request gave no result");

endmodule

bind fixed_point_lowpass_biquad_core bqd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bqd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (upstream.valid),
    .in_ready  (upstream.ready),
    .out_valid (downstream.valid),
    .out_ready (downstream.ready),
    .out_data  (downstream.sample_out)
);
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Low-pass biquad core testbench
// Sends raw samples through the valid/ready channels under bursty traffic and
// receiver stalls. A bit-accurate filter model in a scoreboard class predicts
// every filtered sample. Several coefficient sets are loaded, the extremes
// among them, between runs of traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int IDX_BITS    = bqd_pkg::CFG_IDX_BITS;
    localparam int DATA_BITS   = bqd_pkg::CFG_DATA_BITS;

    // Mirror of the filter: settings, sample history and the samples still owed
    class filter_scoreboard;
        bqd_pkg::bqd_cfg_t             settings;
        logic [31:0]                   prior_in [2];
        logic [31:0]                   prior_out [2];
        logic signed [SAMPLE_BITS-1:0] owed_samples [$];
        int                            failures;

        function new();
            settings     = '0;
            prior_in[0]  = '0;
            prior_in[1]  = '0;
            prior_out[0] = '0;
            prior_out[1] = '0;
            failures     = 0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
            case (idx)
                bqd_pkg::CFG_TAP_GAIN:
                    settings.tap_gain     = data[bqd_pkg::GAIN_BITS-1:0];
                bqd_pkg::CFG_FEEDBACK_ONE:
                    settings.feedback_one = data[bqd_pkg::FB_BITS-1:0];
                bqd_pkg::CFG_FEEDBACK_TWO:
                    settings.feedback_two = data[bqd_pkg::FB_BITS-1:0];
                bqd_pkg::CFG_SCALE_SHIFT:
                    settings.scale_shift  = data[bqd_pkg::SHIFT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // One filter step: wrapping 32-bit sum, scale shift, radix shift, clamp
        function logic signed [SAMPLE_BITS-1:0] next_filtered(logic signed [SAMPLE_BITS-1:0] x);
            logic signed [31:0]            x_now;
            logic [31:0]                   taps;
            logic [31:0]                   gain_w;
            logic [31:0]                   fb1_w;
            logic [31:0]                   fb2_w;
            logic [31:0]                   acc;
            logic signed [31:0]            y_now;
            logic signed [31:0]            scaled;
            logic signed [SAMPLE_BITS-1:0] clipped;
            x_now  = x;
            taps   = prior_in[0] + (prior_in[1] << 1) + x_now;
            gain_w = {{(32 - bqd_pkg::GAIN_BITS){1'b0}}, settings.tap_gain};
            fb1_w  = {{(32 - bqd_pkg::FB_BITS){1'b0}}, settings.feedback_one};
            fb2_w  = {{(32 - bqd_pkg::FB_BITS){settings.feedback_two[bqd_pkg::FB_BITS-1]}},
                      settings.feedback_two};
            acc    = taps * gain_w + fb2_w * prior_out[0] + fb1_w * prior_out[1];
            y_now  = $signed(acc) >>> settings.scale_shift;
            prior_in[0]  = prior_in[1];
            prior_in[1]  = x_now;
            prior_out[0] = prior_out[1];
            prior_out[1] = y_now;
            scaled = y_now >>> bqd_pkg::RADIX_SHIFT;
            if (scaled > SAMPLE_MAX)
                clipped = SAMPLE_BITS'(SAMPLE_MAX);
            else if (scaled < SAMPLE_MIN)
                clipped = SAMPLE_BITS'(SAMPLE_MIN);
            else
                clipped = scaled[SAMPLE_BITS-1:0];
            return clipped;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
            owed_samples.push_back(next_filtered(x));
        endfunction

        function void check_sample(logic signed [SAMPLE_BITS-1:0] got);
            logic signed [SAMPLE_BITS-1:0] want;
            if (owed_samples.size() == 0)
            begin
                $error("sample_out: unexpected filtered sample %0d", got);
                failures++;
                return;
            end
            want = owed_samples.pop_front();
            if (got !== want)
            begin
                $error("sample_out mismatch: expected %0d, got %0d", want, got);
                failures++;
            end
        endfunction

        function int pending();
            return owed_samples.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_BITS-1:0]  cfg_index;
    logic [DATA_BITS-1:0] cfg_data;

    bqd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) upstream_ch ();
    bqd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) downstream_ch ();

    filter_scoreboard sb = new();

    // Traffic shaping, set per phase by the stimulus
    int burst_left = 0;
    bit gaps_on    = 1'b0;
    int stall_mode = 0;
    int stall_tick = 0;
    int hold_left  = 0;
    bit hold_level = 1'b1;

    fixed_point_lowpass_biquad_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .upstream   (upstream_ch),
        .downstream (downstream_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (downstream_ch.valid && downstream_ch.ready)
                sb.check_sample(downstream_ch.sample_out);
            if (upstream_ch.valid && upstream_ch.ready)
                sb.note_sample(upstream_ch.sample_in);
        end
    end

    // Receiver stall pattern
    initial
    begin
        downstream_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_tick++;
            case (stall_mode)
                0: downstream_ch.ready <= 1'b1;
                1: downstream_ch.ready <= ($urandom_range(0, 3) != 0);
                2: downstream_ch.ready <= ((stall_tick % 5) != 4);
                default:
                begin
                    if (hold_left == 0)
                    begin
                        hold_level = ~hold_level;
                        hold_left  = $urandom_range(1, 12);
                    end
                    hold_left--;
                    downstream_ch.ready <= hold_level;
                end
            endcase
        end
    end

    // Write one register; the caller lowers the write enable
    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic load_settings(logic [DATA_BITS-1:0] gain, logic [DATA_BITS-1:0] fb1,
                                 logic [DATA_BITS-1:0] fb2, logic [DATA_BITS-1:0] shift);
        write_reg(bqd_pkg::CFG_TAP_GAIN, gain);
        write_reg(bqd_pkg::CFG_FEEDBACK_ONE, fb1);
        write_reg(bqd_pkg::CFG_FEEDBACK_TWO, fb2);
        write_reg(bqd_pkg::CFG_SCALE_SHIFT, shift);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait for every owed sample, then let the pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        upstream_ch.valid <= 1'b0;
        while (sb.pending() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    // Send one request, with a random gap when a burst runs out and gaps are on
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                upstream_ch.valid <= 1'b0;
                repeat (gap)
                begin
                    upstream_ch.sample_in <= SAMPLE_BITS'($urandom);
                    @(negedge clk);
                end
            end
        end
        burst_left--;
        upstream_ch.valid     <= 1'b1;
        upstream_ch.sample_in <= s;
        do
            @(posedge clk);
        while (!upstream_ch.ready);
        @(negedge clk);
    endtask

    // Pick a coefficient set for a random phase
    task automatic load_phase_settings(int kind);
        longint               unit;
        int                   shift;
        logic [DATA_BITS-1:0] gain;
        logic [DATA_BITS-1:0] fb1;
        logic [DATA_BITS-1:0] fb2;
        case (kind)
            0:
            begin
                // Plausible low-pass poles in fixed point
                shift = $urandom_range(12, 24);
                unit  = longint'(1) << shift;
                gain  = DATA_BITS'(unit * $urandom_range(5, 250) / 1000);
                fb1   = DATA_BITS'(unit * $urandom_range(1200, 1900) / 1000);
                fb2   = DATA_BITS'(-(unit * $urandom_range(400, 950) / 1000));
                load_settings(gain, fb1, fb2, DATA_BITS'(shift));
            end
            1:
            begin
                // Any bit pattern, including ignored upper bits and large shifts
                load_settings(DATA_BITS'($urandom), DATA_BITS'($urandom),
                              DATA_BITS'($urandom), DATA_BITS'($urandom));
            end
            default:
            begin
                gain = $urandom_range(0, 1) ? DATA_BITS'(33554431) : '0;
                fb1  = $urandom_range(0, 1) ? DATA_BITS'(67108863) : '0;
                fb2  = $urandom_range(0, 1) ? DATA_BITS'(-33554432) : '0;
                case ($urandom_range(0, 2))
                    0:       shift = 0;
                    1:       shift = 28;
                    default: shift = 31;
                endcase
                load_settings(gain, fb1, fb2, DATA_BITS'(shift));
            end
        endcase
    endtask

    initial
    begin
        int                            seg_kind;
        int                            seg_left;
        logic signed [SAMPLE_BITS-1:0] held;
        logic signed [SAMPLE_BITS-1:0] s;

        rst_n                 = 1'b0;
        upstream_ch.valid     = 1'b0;
        upstream_ch.sample_in = '0;
        cfg_we                = 1'b0;
        cfg_index             = bqd_pkg::CFG_TAP_GAIN;
        cfg_data              = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: settings left at reset
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        settle();

        // Directed: plain binomial sum, full-scale and sign-boundary samples
        load_settings(26'd1, '0, '0, '0);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        settle();

        // Directed: output clamped at both ends
        load_settings(26'd8, '0, '0, '0);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        settle();

        // Directed: extreme coefficients with the largest shift
        load_settings(26'h1FFFFFF, 26'h3FFFFFF, 26'h2000000, 26'd31);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        settle();

        // Directed: sum wraps past 32 bits
        load_settings(26'h1000000, 26'd1, '0, '0);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        settle();

        // Random phases
        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_phase_settings(phase % 3);
            gaps_on    = (phase % 4) != 3;
            stall_mode = phase % 4;
            burst_left = 0;
            seg_left   = 0;
            seg_kind   = 0;
            held       = '0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (seg_left == 0)
                begin
                    seg_kind = $urandom_range(0, 3);
                    seg_left = $urandom_range(1, 30);
                    held     = SAMPLE_BITS'($urandom);
                end
                seg_left--;
                case (seg_kind)
                    0:       s = SAMPLE_BITS'($urandom);
                    1:       s = held;
                    2:       s = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
                    default: s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                endcase
                send_sample(s);
            end
            settle();
        end

        // Drain and report
        settle();
        repeat (6) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $error("sample_out: %0d filtered samples never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("** fixed_point_lowpass_biquad_core: PASSED **");
        else
            $display("** fixed_point_lowpass_biquad_core: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #8000000;
        $display("** fixed_point_lowpass_biquad_core: FAILED **");
        $finish;
    end

endmodule
